### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the pixel writer.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hw/rtl/rrpw_pkg.sv
// Package of the rotated RGB pixel writer: sizes, codes, the work item type
// and small helper functions. Depends on nothing.
package rrpw_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int POS_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = POS_W + 1;
  localparam int ADDR_W     = 22;
  localparam int ADDR_CALC_W = (POS_W + SIDE_W + 2 > ADDR_W) ? POS_W + SIDE_W + 2 : ADDR_W;
  localparam int CMP_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  // The queue depth must be a power of two so the pointers wrap on their own.
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int RECIP_W    = 17;
  localparam int RECIP_SHIFT = 16;

  localparam logic [1:0] CMD_FG    = 2'd0;
  localparam logic [1:0] CMD_BLEND = 2'd1;
  localparam logic [1:0] CMD_IMAGE = 2'd2;
  localparam logic [1:0] CMD_BG    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_L   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_T   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_W   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_H   = 3'd7;

  typedef struct packed {
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [10:0] frame_w;
    logic [10:0] frame_h;
    logic [9:0]  clip_l;
    logic [9:0]  clip_t;
    logic [10:0] clip_w;
    logic [10:0] clip_h;
  } rrpw_cfg_t;

  // One kept pixel on its way from the front to the back. Channel 2 is red,
  // 1 green, 0 blue. Every command is expressed as a blend.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [2:0][7:0]  fg;
    logic [2:0][7:0]  bg;
    logic [7:0]       alpha;
    logic [3:0]       depth;
  } rrpw_item_t;

  function automatic logic [SIDE_W-1:0] rrpw_clamp_side(input logic [10:0] s);
    rrpw_clamp_side = (int'(s) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(s);
  endfunction

  // Largest alpha for a depth that is already clamped to 1..8.
  function automatic logic [7:0] rrpw_alpha_max(input logic [3:0] depth);
    rrpw_alpha_max = 8'((9'd1 << depth) - 9'd1);
  endfunction

  // floor(2^16 / (2^depth - 1)); the quotient estimate is at most one low.
  function automatic logic [RECIP_W-1:0] rrpw_recip(input logic [3:0] depth);
    logic [RECIP_W-1:0] r;
    unique case (depth)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd21845;
      4'd3:    r = 17'd9362;
      4'd4:    r = 17'd4369;
      4'd5:    r = 17'd2114;
      4'd6:    r = 17'd1040;
      4'd7:    r = 17'd516;
      4'd8:    r = 17'd257;
      default: r = 17'd65536;
    endcase
    rrpw_recip = r;
  endfunction

endpackage

### hw/rtl/rrpw_front.sv
// Front of the pixel writer: frame and clip tests, rotation, alpha setup.
// Depends on rrpw_pkg.
module rrpw_front (
  input  rrpw_pkg::rrpw_cfg_t  cfg_i,
  input  logic [1:0]           command_i,
  input  logic signed [11:0]   x_coord_i,
  input  logic signed [11:0]   y_coord_i,
  input  logic [7:0]           alpha_i,
  input  logic [3:0]           alpha_depth_i,
  input  logic [7:0]           red_in_i,
  input  logic [7:0]           green_in_i,
  input  logic [7:0]           blue_in_i,
  output logic                 keep_o,
  output rrpw_pkg::rrpw_item_t item_o
);
  import rrpw_pkg::*;

  logic [SIDE_W-1:0] w, h;
  logic [CMP_W-1:0]  xc, yc, wc, hc;
  logic              in_frame, in_clip;
  logic [3:0]        depth;
  logic [7:0]        amax, asat;

  assign w  = rrpw_clamp_side(cfg_i.frame_w);
  assign h  = rrpw_clamp_side(cfg_i.frame_h);
  assign xc = CMP_W'(unsigned'(x_coord_i[10:0]));
  assign yc = CMP_W'(unsigned'(y_coord_i[10:0]));
  assign wc = CMP_W'(w);
  assign hc = CMP_W'(h);

  assign in_frame = !x_coord_i[11] && !y_coord_i[11] && (xc < wc) && (yc < hc);
  assign in_clip  = (xc >= CMP_W'(cfg_i.clip_l)) &&
                    (xc < CMP_W'(cfg_i.clip_l) + CMP_W'(cfg_i.clip_w)) &&
                    (yc >= CMP_W'(cfg_i.clip_t)) &&
                    (yc < CMP_W'(cfg_i.clip_t) + CMP_W'(cfg_i.clip_h));
  assign keep_o = in_frame && ((command_i == CMD_BG) || in_clip);

  always_comb begin
    if (alpha_depth_i == 4'd0) begin
      depth = 4'd1;
    end else if (alpha_depth_i > 4'd8) begin
      depth = 4'd8;
    end else begin
      depth = alpha_depth_i;
    end
  end

  assign amax = rrpw_alpha_max(depth);
  assign asat = (alpha_i > amax) ? amax : alpha_i;

  // Plain colors go through the blender as color * 1 / 1, which is exact.
  always_comb begin
    item_o.row   = POS_W'(hc - yc - CMP_W'(1));
    item_o.col   = POS_W'(wc - xc - CMP_W'(1));
    item_o.bg    = '0;
    item_o.alpha = 8'd1;
    item_o.depth = 4'd1;
    unique case (command_i)
      CMD_FG: begin
        item_o.fg = cfg_i.fg_color;
      end
      CMD_BLEND: begin
        item_o.fg    = cfg_i.fg_color;
        item_o.bg    = cfg_i.bg_color;
        item_o.alpha = asat;
        item_o.depth = depth;
      end
      CMD_IMAGE: begin
        item_o.fg = {red_in_i, green_in_i, blue_in_i};
      end
      CMD_BG: begin
        item_o.fg = cfg_i.bg_color;
      end
      default: begin
        item_o.fg = cfg_i.fg_color;
      end
    endcase
  end

endmodule

### hw/rtl/rrpw_queue.sv
// Short register queue that decouples the front from the back.
// Depends on rrpw_pkg.
module rrpw_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rrpw_pkg::rrpw_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output rrpw_pkg::rrpw_item_t item_o
);
  import rrpw_pkg::*;

  rrpw_item_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/rrpw_back.sv
// Back of the pixel writer: four-stage pipeline for address and blend.
// Depends on rrpw_pkg.
module rrpw_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [10:0]            frame_w_i,
  input  logic                   q_valid_i,
  input  rrpw_pkg::rrpw_item_t   q_item_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [21:0]            pixel_address_o,
  output logic [7:0]             red_out_o,
  output logic [7:0]             green_out_o,
  output logic [7:0]             blue_out_o
);
  import rrpw_pkg::*;

  logic                   en;
  logic [SIDE_W-1:0]      w;
  logic                   v1_q, v2_q, v3_q, v4_q;

  // Stage 1: products.
  logic [2:0][15:0]       fa1_q, bm1_q;
  logic [ADDR_CALC_W-1:0] rw1_q;
  logic [POS_W-1:0]       col1_q;
  logic [3:0]             d1_q;
  // Stage 2: numerators and pixel index.
  logic [2:0][15:0]       n2_q;
  logic [ADDR_CALC_W-1:0] pa2_q;
  logic [3:0]             d2_q;
  logic [2:0][15:0]       n2_d;
  // Stage 3: quotient estimates and byte address.
  logic [2:0][15:0]       n3_q;
  logic [2:0][7:0]        qe3_q, qe3_d;
  logic [ADDR_W-1:0]      addr3_q;
  logic [3:0]             d3_q;
  logic [2:0][7:0]        q4_d;
  logic [7:0]             amax1, amax3;

  assign w       = rrpw_clamp_side(frame_w_i);
  assign en      = !v4_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;
  assign amax1   = rrpw_alpha_max(q_item_i.depth);
  assign amax3   = rrpw_alpha_max(d3_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n2_d[c] = fa1_q[c] + bm1_q[c];
    end
  end

  always_comb begin
    logic [RECIP_W+15:0] prod;
    logic [RECIP_W-1:0]  r;
    r = rrpw_recip(d2_q);
    for (int c = 0; c < 3; c++) begin
      prod     = (RECIP_W+16)'(n2_q[c]) * (RECIP_W+16)'(r);
      qe3_d[c] = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    end
  end

  // The estimate is exact or one low; a single compare fixes it.
  always_comb begin
    logic [15:0] qm, rem;
    for (int c = 0; c < 3; c++) begin
      qm      = (16'(qe3_q[c]) << d3_q) - 16'(qe3_q[c]);
      rem     = n3_q[c] - qm;
      q4_d[c] = (rem >= 16'(amax3)) ? qe3_q[c] + 8'd1 : qe3_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        fa1_q[c] <= 16'(q_item_i.fg[c]) * 16'(q_item_i.alpha);
        bm1_q[c] <= 16'(q_item_i.bg[c]) * 16'(amax1 - q_item_i.alpha);
      end
      rw1_q   <= ADDR_CALC_W'(q_item_i.row) * ADDR_CALC_W'(w);
      col1_q  <= q_item_i.col;
      d1_q    <= q_item_i.depth;

      n2_q    <= n2_d;
      pa2_q   <= rw1_q + ADDR_CALC_W'(col1_q);
      d2_q    <= d1_q;

      n3_q    <= n2_q;
      qe3_q   <= qe3_d;
      addr3_q <= ADDR_W'((pa2_q << 1) + pa2_q);
      d3_q    <= d2_q;

      pixel_address_o <= addr3_q;
      red_out_o       <= q4_d[2];
      green_out_o     <= q4_d[1];
      blue_out_o      <= q4_d[0];
    end
  end

  assign out_valid_o = v4_q;

endmodule

### hw/rtl/rotated_rgb_pixel_writer.sv
// Pixel writer for a 180-degree rotated RGB888 frame, top level.
// Holds the configuration registers; depends on rrpw_pkg, rrpw_front,
// rrpw_queue, rrpw_back and assert_macros.svh.
//
// Usage: pixel writes enter through a queue-like port: an item is taken
// when push is high and full is low. Items outside the frame, or outside
// the clip rectangle for all but the background command, are taken and
// dropped without a result. Each kept item yields one transfer on the
// result side, oldest first: the result is on the ports while empty is low
// and leaves when pop is high.
// A kept item passes through the queue and the four back stages to the ports.
// Throughput: one item per cycle while pop is high, set by the four-stage
// back pipeline that holds one pixel in each stage.
// When the receiver stalls, the back pipeline holds and the four-entry queue
// between front and back fills; full rises once it is full.
// Reset clears the queue and the pipeline (empty high, full low) and loads
// the registers with white foreground, black background, a 1024 x 1024
// frame and a full-frame clip rectangle. Write registers only while idle.
`include "assert_macros.svh"

module rotated_rgb_pixel_writer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rrpw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rrpw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           command_i,
  input  logic signed [11:0]                   x_coord_i,
  input  logic signed [11:0]                   y_coord_i,
  input  logic [7:0]                           alpha_i,
  input  logic [3:0]                           alpha_depth_i,
  input  logic [7:0]                           red_in_i,
  input  logic [7:0]                           green_in_i,
  input  logic [7:0]                           blue_in_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [21:0]                          pixel_address_o,
  output logic [7:0]                           red_out_o,
  output logic [7:0]                           green_out_o,
  output logic [7:0]                           blue_out_o
);
  import rrpw_pkg::*;

  rrpw_cfg_t  cfg_q;
  rrpw_item_t front_item, q_item;
  logic       keep, q_push, q_full, q_valid, q_pop, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color <= 24'hFFFFFF;
      cfg_q.bg_color <= 24'h000000;
      cfg_q.frame_w  <= 11'd1024;
      cfg_q.frame_h  <= 11'd1024;
      cfg_q.clip_l   <= 10'd0;
      cfg_q.clip_t   <= 10'd0;
      cfg_q.clip_w   <= 11'd1024;
      cfg_q.clip_h   <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FG_COLOR: cfg_q.fg_color <= cfg_data_i;
        REG_BG_COLOR: cfg_q.bg_color <= cfg_data_i;
        REG_FRAME_W:  cfg_q.frame_w  <= cfg_data_i[10:0];
        REG_FRAME_H:  cfg_q.frame_h  <= cfg_data_i[10:0];
        REG_CLIP_L:   cfg_q.clip_l   <= cfg_data_i[9:0];
        REG_CLIP_T:   cfg_q.clip_t   <= cfg_data_i[9:0];
        REG_CLIP_W:   cfg_q.clip_w   <= cfg_data_i[10:0];
        REG_CLIP_H:   cfg_q.clip_h   <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  rrpw_front u_front (
    .cfg_i         (cfg_q),
    .command_i     (command_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .alpha_i       (alpha_i),
    .alpha_depth_i (alpha_depth_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .keep_o        (keep),
    .item_o        (front_item)
  );

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

  rrpw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  rrpw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_w_i       (cfg_q.frame_w),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid),
    .out_ready_i     (pop),
    .pixel_address_o (pixel_address_o),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o)
  );

  assign empty = !out_valid;

  // The back only takes items that the queue really holds.
  `ASSERT_RST(a_pop_needs_item, clk_i, rst_ni, q_pop |-> q_valid, "back popped an empty queue")
  // Only an accepted input item can be written into the queue.
  `ASSERT_RST(a_push_from_accept, clk_i, rst_ni, q_push |-> (push && !full && keep), "queue written without an accepted item")
  // Reset leaves no stale result on the output side.
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty, "result present during reset")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of rotated_rgb_pixel_writer. Depends on rrpw_pkg
// and the RTL; predicts every stored pixel and compares it in arrival order.
module tb_top;
  import rrpw_pkg::*;

  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [11:0] x_coord;
    logic signed [11:0] y_coord;
    logic [7:0]         alpha;
    logic [3:0]         alpha_depth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_write_t;

  typedef struct packed {
    logic [21:0] pixel_address;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_store_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] command_i = CMD_FG;
  logic signed [11:0] x_coord_i = '0;
  logic signed [11:0] y_coord_i = '0;
  logic [7:0] alpha_i = '0;
  logic [3:0] alpha_depth_i = 4'd1;
  logic [7:0] red_in_i = '0;
  logic [7:0] green_in_i = '0;
  logic [7:0] blue_in_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [21:0] pixel_address_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;

  // Register copies used for prediction.
  logic [23:0] fg_color_q = 24'hFFFFFF;
  logic [23:0] bg_color_q = 24'h000000;
  logic [10:0] frame_w_q = 11'd1024;
  logic [10:0] frame_h_q = 11'd1024;
  logic [9:0]  clip_l_q = '0;
  logic [9:0]  clip_t_q = '0;
  logic [10:0] clip_w_q = 11'd1024;
  logic [10:0] clip_h_q = 11'd1024;

  pixel_write_t pending_writes[$];
  pixel_store_t predicted_stores[$];
  pixel_write_t cur_write;
  int fail_count = 0;
  int send_idle_pct = 34;
  int recv_idle_pct = 34;

  rotated_rgb_pixel_writer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .alpha_i         (alpha_i),
    .alpha_depth_i   (alpha_depth_i),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .empty           (empty),
    .pop             (pop),
    .pixel_address_o (pixel_address_o),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int clamped_side(input logic [10:0] s);
    return (int'(s) > MAX_SIDE) ? MAX_SIDE : int'(s);
  endfunction

  function automatic logic [7:0] blend_channel(input int unsigned f, input int unsigned b,
                                               input int unsigned a, input int unsigned m);
    return 8'((f * a + b * (m - a)) / m);
  endfunction

  // Returns 1 and fills the store when the pixel survives the frame and clip tests.
  function automatic bit shade_pixel(input pixel_write_t p, output pixel_store_t s);
    int w;
    int h;
    int x;
    int y;
    int unsigned dep;
    int unsigned amax;
    int unsigned a;
    longint addr;
    w = clamped_side(frame_w_q);
    h = clamped_side(frame_h_q);
    x = int'(p.x_coord);
    y = int'(p.y_coord);
    s = '0;
    if (x < 0 || y < 0 || x >= w || y >= h) return 0;
    if (p.command != CMD_BG) begin
      if (x < int'(clip_l_q) || x >= int'(clip_l_q) + int'(clip_w_q) ||
          y < int'(clip_t_q) || y >= int'(clip_t_q) + int'(clip_h_q)) return 0;
    end
    case (p.command)
      CMD_FG: begin
        {s.red, s.green, s.blue} = fg_color_q;
      end
      CMD_BLEND: begin
        dep = p.alpha_depth;
        if (dep < 1) dep = 1;
        if (dep > 8) dep = 8;
        amax = (1 << dep) - 1;
        a = (p.alpha > amax) ? amax : p.alpha;
        s.red   = blend_channel(fg_color_q[23:16], bg_color_q[23:16], a, amax);
        s.green = blend_channel(fg_color_q[15:8], bg_color_q[15:8], a, amax);
        s.blue  = blend_channel(fg_color_q[7:0], bg_color_q[7:0], a, amax);
      end
      CMD_IMAGE: begin
        s.red = p.red;
        s.green = p.green;
        s.blue = p.blue;
      end
      default: begin
        {s.red, s.green, s.blue} = bg_color_q;
      end
    endcase
    // The frame is rotated by 180 degrees before the address is formed.
    addr = (longint'(h - y - 1) * w + longint'(w - x - 1)) * 3;
    s.pixel_address = 22'(addr);
    return 1;
  endfunction

  function automatic pixel_write_t make_write(input logic [1:0] c, input int x, input int y,
                                              input int a, input int d,
                                              input logic [23:0] rgb);
    pixel_write_t p;
    p.command = c;
    p.x_coord = 12'(x);
    p.y_coord = 12'(y);
    p.alpha = 8'(a);
    p.alpha_depth = 4'(d);
    {p.red, p.green, p.blue} = rgb;
    return p;
  endfunction

  // A coordinate one step around the span [lo, lo + span).
  function automatic int near_span(input int lo, input int span);
    return lo - 1 + int'($urandom_range(span + 1));
  endfunction

  function automatic pixel_write_t random_write();
    int sel;
    int x;
    int y;
    int d;
    sel = $urandom_range(9);
    if (sel < 5) begin
      x = near_span(clip_l_q, clip_w_q);
      y = near_span(clip_t_q, clip_h_q);
    end else if (sel < 8) begin
      x = near_span(0, clamped_side(frame_w_q));
      y = near_span(0, clamped_side(frame_h_q));
    end else begin
      x = $urandom;
      y = $urandom;
    end
    d = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
    return make_write(2'($urandom_range(3)), x, y, $urandom_range(255), d, 24'($urandom));
  endfunction

  // Driver: the current write stays on the ports until a transfer takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        pixel_store_t s;
        if (shade_pixel(cur_write, s)) predicted_stores.push_back(s);
      end
      if (!push || !full) begin
        if (pending_writes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_write = pending_writes.pop_front();
          command_i <= cur_write.command;
          x_coord_i <= cur_write.x_coord;
          y_coord_i <= cur_write.y_coord;
          alpha_i <= cur_write.alpha;
          alpha_depth_i <= cur_write.alpha_depth;
          red_in_i <= cur_write.red;
          green_in_i <= cur_write.green;
          blue_in_i <= cur_write.blue;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        pixel_store_t s;
        if (predicted_stores.size() == 0) begin
          $error("unexpected store: pixel_address %0h", pixel_address_o);
          fail_count++;
        end else begin
          s = predicted_stores.pop_front();
          if (pixel_address_o !== s.pixel_address) begin
            $error("pixel_address: expected %0h, got %0h", s.pixel_address, pixel_address_o);
            fail_count++;
          end
          if (red_out_o !== s.red) begin
            $error("red_out: expected %0h, got %0h", s.red, red_out_o);
            fail_count++;
          end
          if (green_out_o !== s.green) begin
            $error("green_out: expected %0h, got %0h", s.green, green_out_o);
            fail_count++;
          end
          if (blue_out_o !== s.blue) begin
            $error("blue_out: expected %0h, got %0h", s.blue, blue_out_o);
            fail_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FG_COLOR: fg_color_q = val;
      REG_BG_COLOR: bg_color_q = val;
      REG_FRAME_W:  frame_w_q = val[10:0];
      REG_FRAME_H:  frame_h_q = val[10:0];
      REG_CLIP_L:   clip_l_q = val[9:0];
      REG_CLIP_T:   clip_t_q = val[9:0];
      REG_CLIP_W:   clip_w_q = val[10:0];
      default:      clip_h_q = val[10:0];
    endcase
  endtask

  task automatic set_regs(input logic [23:0] fg, input logic [23:0] bg, input int w,
                          input int h, input int cl, input int ct, input int cw, input int ch);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_FRAME_W, 24'(w));
    write_reg(REG_FRAME_H, 24'(h));
    write_reg(REG_CLIP_L, 24'(cl));
    write_reg(REG_CLIP_T, 24'(ct));
    write_reg(REG_CLIP_W, 24'(cw));
    write_reg(REG_CLIP_H, 24'(ch));
  endtask

  // Every write transferred and every store seen, then room for dropped writes.
  task automatic run_writes(input int count);
    repeat (count) pending_writes.push_back(random_write());
    while (pending_writes.size() != 0 || push || predicted_stores.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int w;
    int h;
    int cl;
    int ct;
    // The falling reset edge lands after every process waits, so the
    // asynchronous reset takes effect before the first clock edge.
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: corners, frame edges, alpha saturation and odd depths.
    pending_writes.push_back(make_write(CMD_FG, 0, 0, 0, 8, 24'h000000));
    pending_writes.push_back(make_write(CMD_BLEND, 1023, 1023, 0, 8, 24'h000000));
    pending_writes.push_back(make_write(CMD_IMAGE, 0, 1023, 0, 1, 24'hFF00FF));
    pending_writes.push_back(make_write(CMD_IMAGE, 1023, 0, 0, 1, 24'h00FF00));
    pending_writes.push_back(make_write(CMD_IMAGE, 100, 200, 255, 15, 24'hFFFFFF));
    pending_writes.push_back(make_write(CMD_BG, 512, 511, 255, 15, 24'hFFFFFF));
    pending_writes.push_back(make_write(CMD_BLEND, 5, 7, 255, 8, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 5, 7, 128, 8, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 6, 7, 200, 4, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 6, 8, 1, 0, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 6, 9, 128, 15, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 7, 9, 0, 1, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 7, 10, 3, 2, 24'h0));
    pending_writes.push_back(make_write(CMD_BLEND, 7, 11, 1, 1, 24'h0));
    pending_writes.push_back(make_write(CMD_FG, -1, 0, 0, 8, 24'h0));
    pending_writes.push_back(make_write(CMD_BG, 0, -1, 0, 8, 24'h0));
    pending_writes.push_back(make_write(CMD_IMAGE, 1024, 5, 0, 8, 24'h123456));
    pending_writes.push_back(make_write(CMD_BLEND, 5, 1024, 9, 3, 24'h0));
    pending_writes.push_back(make_write(CMD_FG, -2048, -2048, 0, 8, 24'h0));
    pending_writes.push_back(make_write(CMD_BG, 2047, 2047, 0, 8, 24'h0));
    run_writes(0);

    // Single-pixel frame.
    set_regs(24'hFFFFFF, 24'h000000, 1, 1, 0, 0, 1, 1);
    run_writes(40);
    // Oversized frame saturates; clip rectangle runs past the frame.
    set_regs(24'h000000, 24'hFFFFFF, 2047, 2047, 1023, 1023, 1024, 1024);
    run_writes(80);
    // Empty clip rectangle: only background fills get through.
    set_regs(24'($urandom), 24'($urandom), $urandom_range(64, 1), $urandom_range(64, 1),
             0, 0, 0, 0);
    run_writes(60);
    // Zero-width frame drops everything.
    set_regs(24'($urandom), 24'($urandom), 0, $urandom_range(64, 1), 0, 0, 1024, 1024);
    run_writes(20);

    for (int phase = 0; phase < 6; phase++) begin
      w = ($urandom_range(3) == 0) ? $urandom_range(1024, 1) : $urandom_range(48, 1);
      h = ($urandom_range(3) == 0) ? $urandom_range(1024, 1) : $urandom_range(48, 1);
      cl = $urandom_range(w > 1023 ? 1023 : w);
      ct = $urandom_range(h > 1023 ? 1023 : h);
      // One phase runs without any idling on either side.
      send_idle_pct = (phase == 2) ? 0 : 34;
      recv_idle_pct = (phase == 2) ? 0 : 34;
      set_regs(24'($urandom), 24'($urandom), w, h, cl, ct,
               $urandom_range(w + 2 > 1024 ? 1024 : w + 2),
               $urandom_range(h + 2 > 1024 ? 1024 : h + 2));
      run_writes(90);
    end

    if (fail_count == 0 && predicted_stores.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### rotated_rgb_pixel_writer.f
+incdir+hw/rtl
hw/rtl/rrpw_pkg.sv
hw/rtl/rrpw_front.sv
hw/rtl/rrpw_queue.sv
hw/rtl/rrpw_back.sv
hw/rtl/rotated_rgb_pixel_writer.sv
dv/tb_top.sv
